/* rtl/core/pres80_pkg.sv */
// PRESENT-80 shared types, constants and round/key-schedule functions.
`timescale 1ns / 1ps

package pres80_pkg;

    localparam int ROUNDS    = 31;
    localparam int BLOCK_W   = 64;
    localparam int KEY_W     = 80;
    localparam int KLO_W     = 16;
    localparam int RC_W      = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_UPPER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOWER = 1'b1;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef struct packed {
        logic valid;
        logic op;
    } t_ctrl;

    localparam logic [3:0] SBOX_FWD [16] = '{
        4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
        4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };
    localparam logic [3:0] SBOX_INV [16] = '{
        4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
        4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA
    };

    function automatic logic [BLOCK_W-1:0] sub_fwd(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] r;
        for (int n = 0; n < 16; n++) begin
            r[4*n +: 4] = SBOX_FWD[x[4*n +: 4]];
        end
        return r;
    endfunction

    function automatic logic [BLOCK_W-1:0] sub_inv(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] r;
        for (int n = 0; n < 16; n++) begin
            r[4*n +: 4] = SBOX_INV[x[4*n +: 4]];
        end
        return r;
    endfunction

    // bit i moves to bit 16*(i mod 4) + i/4
    function automatic logic [BLOCK_W-1:0] perm_fwd(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] r;
        for (int i = 0; i < BLOCK_W; i++) begin
            r[16*(i%4) + i/4] = x[i];
        end
        return r;
    endfunction

    function automatic logic [BLOCK_W-1:0] perm_inv(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] r;
        for (int i = 0; i < BLOCK_W; i++) begin
            r[i] = x[16*(i%4) + i/4];
        end
        return r;
    endfunction

    // rotate left 61, S-box on top nibble, counter into bits 19..15
    function automatic logic [KEY_W-1:0] key_fwd(input logic [KEY_W-1:0] k,
                                                 input logic [RC_W-1:0] rc);
        logic [KEY_W-1:0] t;
        t = {k[18:0], k[79:19]};
        t[79:76] = SBOX_FWD[t[79:76]];
        t[19:15] = t[19:15] ^ rc;
        return t;
    endfunction

    function automatic logic [KEY_W-1:0] key_inv(input logic [KEY_W-1:0] k,
                                                 input logic [RC_W-1:0] rc);
        logic [KEY_W-1:0] t;
        t = k;
        t[19:15] = t[19:15] ^ rc;
        t[79:76] = SBOX_INV[t[79:76]];
        return {t[60:0], t[79:61]};
    endfunction

endpackage

/* rtl/core/pres80_round_cell.sv */
// One pipeline cell: a cipher round plus one key-schedule step.
`timescale 1ns / 1ps

module pres80_round_cell #(
    parameter bit                           INVERSE = 1'b0,
    parameter logic [pres80_pkg::RC_W-1:0] RC      = 5'd1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  pres80_pkg::t_ctrl              i_ctrl,
    input  logic [pres80_pkg::BLOCK_W-1:0] i_data,
    input  logic [pres80_pkg::KEY_W-1:0]   i_key,
    output pres80_pkg::t_ctrl              o_ctrl,
    output logic [pres80_pkg::BLOCK_W-1:0] o_data,
    output logic [pres80_pkg::KEY_W-1:0]   o_key
);

    pres80_pkg::t_ctrl              r_ctrl;
    logic [pres80_pkg::BLOCK_W-1:0] r_data, n_data, w_mix;
    logic [pres80_pkg::KEY_W-1:0]   r_key, n_key;

    assign w_mix = i_data ^ i_key[pres80_pkg::KEY_W-1 -: pres80_pkg::BLOCK_W];

    always_comb begin
        n_data = i_data;
        if (INVERSE) begin
            n_key = pres80_pkg::key_inv(i_key, RC);
            if (i_ctrl.op == pres80_pkg::OP_DECRYPT) begin
                n_data = pres80_pkg::sub_inv(pres80_pkg::perm_inv(w_mix));
            end
        end else begin
            n_key = pres80_pkg::key_fwd(i_key, RC);
            if (i_ctrl.op == pres80_pkg::OP_ENCRYPT) begin
                n_data = pres80_pkg::perm_fwd(pres80_pkg::sub_fwd(w_mix));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
            r_key  <= n_key;
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_data = r_data;
    assign o_key  = r_key;

endmodule

/* rtl/core/present80_block_cipher_unit.sv */
// PRESENT-80 encrypt/decrypt unit: a row of round cells in a stalling pipeline.
//
// Usage:
//   Key: write index 0 (upper 64 key bits) and index 1 (lower 16 bits) on the
//   config port while the unit is empty. Both reset to zero.
//   Input channel: i_valid/o_stall carry a request of op (0 enc, 1 dec) and a
//   64-bit block. Output channel: o_valid/i_stall carry the 64-bit result.
//   Datapath: 2*ROUNDS cells in a row. The first ROUNDS cells step the key
//   schedule forward and run the encrypt rounds; the last ROUNDS cells step
//   it backward and run the decrypt rounds. Each request rides with its own
//   key, so blocks flow in order with no gaps.
//   Flow: a request passes all 2*ROUNDS cell registers in order, in both
//   directions. Throughput: one block per cycle, set by the one-round-per-cell
//   pipeline, whenever the row is not held by a stall.
//   Stall: when the last cell holds a result and i_stall is high, the whole
//   row holds and o_stall rises; otherwise every cell, empty or not, advances.
//   Reset: synchronous, clears all cell valid flags and the key registers.
`timescale 1ns / 1ps

module present80_block_cipher_unit #(
    parameter int ROUNDS = pres80_pkg::ROUNDS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pres80_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pres80_pkg::BLOCK_W-1:0]   i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_op,
    input  logic [pres80_pkg::BLOCK_W-1:0]   i_block_in,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [pres80_pkg::BLOCK_W-1:0]   o_block_out
);

    localparam int CELLS = 2 * ROUNDS;

    logic [pres80_pkg::BLOCK_W-1:0] r_key_upper;
    logic [pres80_pkg::KLO_W-1:0]   r_key_lower;
    logic                           w_en;

    pres80_pkg::t_ctrl              w_ctrl [CELLS+1];
    logic [pres80_pkg::BLOCK_W-1:0] w_data [CELLS+1];
    logic [pres80_pkg::KEY_W-1:0]   w_key  [CELLS+1];
    logic [pres80_pkg::BLOCK_W-1:0] w_din  [CELLS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_upper <= '0;
            r_key_lower <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pres80_pkg::REG_KEY_UPPER: r_key_upper <= i_cfg_data;
                pres80_pkg::REG_KEY_LOWER: r_key_lower <= i_cfg_data[pres80_pkg::KLO_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_en      = !(w_ctrl[CELLS].valid && i_stall);
    assign o_stall   = !w_en;
    assign w_ctrl[0] = '{valid: i_valid, op: i_op};
    assign w_data[0] = i_block_in;
    assign w_key[0]  = {r_key_upper, r_key_lower};

    genvar c;
    generate
        for (c = 0; c < CELLS; c++) begin : g_cell
            if (c == ROUNDS) begin : g_mid
                // final key add of encryption, with the last forward key
                assign w_din[c] = (w_ctrl[c].op == pres80_pkg::OP_ENCRYPT) ?
                    (w_data[c] ^ w_key[c][pres80_pkg::KEY_W-1 -: pres80_pkg::BLOCK_W]) :
                    w_data[c];
            end else begin : g_pass
                assign w_din[c] = w_data[c];
            end

            pres80_round_cell #(
                .INVERSE (c >= ROUNDS),
                .RC      ((c < ROUNDS) ? pres80_pkg::RC_W'(c + 1)
                                       : pres80_pkg::RC_W'(CELLS - c))
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_ctrl  (w_ctrl[c]),
                .i_data  (w_din[c]),
                .i_key   (w_key[c]),
                .o_ctrl  (w_ctrl[c+1]),
                .o_data  (w_data[c+1]),
                .o_key   (w_key[c+1])
            );
        end
    endgenerate

    // final key add of decryption, with the restored original key
    assign o_valid     = w_ctrl[CELLS].valid;
    assign o_block_out = (w_ctrl[CELLS].op == pres80_pkg::OP_DECRYPT) ?
        (w_data[CELLS] ^ w_key[CELLS][pres80_pkg::KEY_W-1 -: pres80_pkg::BLOCK_W]) :
        w_data[CELLS];

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output stage");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> w_ctrl[1].valid)
        else $error("accepted request missing from first cell");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(w_ctrl[1]) && $stable(w_data[1])))
        else $error("first cell moved while output stalled");

endmodule
